>>> design/rtcbcd_pkg.sv
package rtcbcd_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_MON  = 3'd1;
	localparam logic [2:0] ST_BAD_DAY  = 3'd2;
	localparam logic [2:0] ST_BAD_TIME = 3'd3;
	localparam logic [2:0] ST_BAD_YEAR = 3'd4;

	localparam logic [11:0] EPOCH_RESET = 12'd2000;

	localparam logic [3:0] MON_FEB  = 4'd2;
	localparam logic [3:0] MON_LAST = 4'd12;
	localparam logic [4:0] HOURS    = 5'd24;
	localparam logic [5:0] MINUTES  = 6'd60;

	// floor(y * 1311 / 2^15) equals floor(y / 25) for every 12-bit y
	localparam logic [10:0] RECIP25 = 11'd1311;
	localparam int          RECIP25_SHIFT = 15;

	// floor(v * 205 / 2^11) equals floor(v / 10) for v below 100
	localparam logic [7:0] RECIP10 = 8'd205;
	localparam int         RECIP10_SHIFT = 11;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [2:0]  weekday;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] bcd_second;
		logic [7:0] bcd_minute;
		logic [7:0] bcd_hour;
		logic [7:0] bcd_day;
		logic [7:0] bcd_weekday;
		logic [7:0] bcd_month;
		logic [7:0] bcd_year;
	} result_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
		logic [3:0] month;
		logic [6:0] year_off;
	} chk_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

>>> design/rtcbcd_check.sv
module rtcbcd_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  rtcbcd_pkg::item_t   item,
	input  logic [11:0]         epoch,
	output logic                vld_s2,
	output rtcbcd_pkg::chk_t    chk_s2
);

	logic        vld_s1;
	logic [11:0] year_s1;
	logic [3:0]  mon_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hr_s1;
	logic [5:0]  mn_s1;
	logic [5:0]  sc_s1;
	logic [2:0]  wd_s1;
	logic        bad_mon_s1;
	logic        bad_time_s1;
	logic        is_feb_s1;
	logic [4:0]  mlen_s1;
	logic        div4_s1;
	logic        div16_s1;
	logic [7:0]  q25_s1;
	logic [12:0] diff_s1;

	logic [22:0] prod25;
	logic [11:0] back25;
	logic        leap;
	logic [5:0]  limit;
	logic [7:0]  off8;
	logic [6:0]  off_mod;
	logic        bad_year;
	rtcbcd_pkg::chk_t chk_d;

	assign prod25 = 23'(item.year) * 23'(rtcbcd_pkg::RECIP25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		year_s1     <= item.year;
		mon_s1      <= item.month;
		day_s1      <= item.day_of_month;
		hr_s1       <= item.hour;
		mn_s1       <= item.minute;
		sc_s1       <= item.second;
		wd_s1       <= item.weekday;
		bad_mon_s1  <= (item.month == 4'd0) || (item.month > rtcbcd_pkg::MON_LAST)
			|| (item.day_of_month == 5'd0);
		bad_time_s1 <= (item.hour >= rtcbcd_pkg::HOURS) || (item.minute >= rtcbcd_pkg::MINUTES)
			|| (item.second >= rtcbcd_pkg::MINUTES);
		is_feb_s1   <= item.month == rtcbcd_pkg::MON_FEB;
		mlen_s1     <= rtcbcd_pkg::month_len(item.month);
		div4_s1     <= item.year[1:0] == 2'd0;
		div16_s1    <= item.year[3:0] == 4'd0;
		q25_s1      <= prod25[rtcbcd_pkg::RECIP25_SHIFT +: 8];
		diff_s1     <= {1'b0, item.year} - {1'b0, epoch};
	end

	// Gregorian leap: divisible by 4, and not by 100 unless by 400
	assign back25 = {q25_s1, 4'd0} + {1'b0, q25_s1, 3'd0} + {4'd0, q25_s1};
	assign leap   = div4_s1 && ((back25 != year_s1) || div16_s1);
	assign limit  = {1'b0, mlen_s1} + {5'd0, is_feb_s1 && leap};

	assign bad_year = diff_s1[12] || (diff_s1[11:8] != 4'd0);
	assign off8     = diff_s1[7:0];

	always_comb begin
		if (off8 >= 8'd200) begin
			off_mod = 7'(off8 - 8'd200);
		end else if (off8 >= 8'd100) begin
			off_mod = 7'(off8 - 8'd100);
		end else begin
			off_mod = off8[6:0];
		end
	end

	always_comb begin
		chk_d.day      = day_s1;
		chk_d.hour     = hr_s1;
		chk_d.minute   = mn_s1;
		chk_d.second   = sc_s1;
		chk_d.weekday  = wd_s1;
		chk_d.month    = mon_s1;
		chk_d.year_off = off_mod;
		if (bad_mon_s1) begin
			chk_d.status = rtcbcd_pkg::ST_BAD_MON;
		end else if ({1'b0, day_s1} > limit) begin
			chk_d.status = rtcbcd_pkg::ST_BAD_DAY;
		end else if (bad_time_s1) begin
			chk_d.status = rtcbcd_pkg::ST_BAD_TIME;
		end else if (bad_year) begin
			chk_d.status = rtcbcd_pkg::ST_BAD_YEAR;
		end else begin
			chk_d.status = rtcbcd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		chk_s2 <= chk_d;
	end

endmodule

>>> design/rtcbcd_pack.sv
module rtcbcd_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_s2,
	input  rtcbcd_pkg::chk_t    chk_s2,
	output logic                vld_s3,
	output rtcbcd_pkg::result_t res_s3
);

	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  units;
		p     = 15'(v) * 15'(rtcbcd_pkg::RECIP10);
		tens  = p[rtcbcd_pkg::RECIP10_SHIFT +: 4];
		units = v - 7'({tens, 3'd0} + {2'd0, tens, 1'b0});
		return {tens, units[3:0]};
	endfunction

	logic                ok;
	rtcbcd_pkg::result_t res_d;

	assign ok = chk_s2.status == rtcbcd_pkg::ST_OK;

	always_comb begin
		res_d.status = chk_s2.status;
		if (ok) begin
			res_d.bcd_second  = to_bcd(chk_s2.second[5:0] > 6'd0 ? {1'b0, chk_s2.second} : 7'd0);
			res_d.bcd_minute  = to_bcd({1'b0, chk_s2.minute});
			res_d.bcd_hour    = to_bcd({2'd0, chk_s2.hour});
			res_d.bcd_day     = to_bcd({2'd0, chk_s2.day});
			res_d.bcd_weekday = {5'd0, chk_s2.weekday};
			res_d.bcd_month   = to_bcd({3'd0, chk_s2.month});
			res_d.bcd_year    = to_bcd(chk_s2.year_off);
		end else begin
			res_d.bcd_second  = 8'd0;
			res_d.bcd_minute  = 8'd0;
			res_d.bcd_hour    = 8'd0;
			res_d.bcd_day     = 8'd0;
			res_d.bcd_weekday = 8'd0;
			res_d.bcd_month   = 8'd0;
			res_d.bcd_year    = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_d;
	end

endmodule

>>> design/rtc_datetime_check_bcd_pack_core.sv
// Channel   Handshake               Payload
// command   start (busy low)        cmd    : item_t
// result    done, one cycle         result : result_t
// config    epoch_we                epoch_wdata (epoch year, 12 bit)
//
// One beat per cycle; the result is registered through the stages below.
// Three register stages: range checks and year math, status and year mod 100,
// BCD encode. busy stays low: every beat is taken.
// Reset clears valid bits and sets the epoch year to 2000.
// The receiver cannot stall; done lasts exactly one cycle per beat.
module rtc_datetime_check_bcd_pack_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rtcbcd_pkg::item_t   cmd,
	output logic                done,
	output rtcbcd_pkg::result_t result,
	input  logic                epoch_we,
	input  logic [11:0]         epoch_wdata
);

	logic [11:0]      epoch_q;
	logic             vld_s2;
	rtcbcd_pkg::chk_t chk_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= rtcbcd_pkg::EPOCH_RESET;
		end else if (epoch_we) begin
			epoch_q <= epoch_wdata;
		end
	end

	rtcbcd_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.item   (cmd),
		.epoch  (epoch_q),
		.vld_s2 (vld_s2),
		.chk_s2 (chk_s2)
	);

	rtcbcd_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.chk_s2 (chk_s2),
		.vld_s3 (done),
		.res_s3 (result)
	);

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BEATS = 195;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rtcbcd_pkg::item_t cmd = '0;
	logic done;
	rtcbcd_pkg::result_t result;
	logic epoch_we = 1'b0;
	logic [11:0] epoch_wdata = '0;

	logic [11:0] epoch_shadow = rtcbcd_pkg::EPOCH_RESET;
	rtcbcd_pkg::result_t expected_dates[$];
	int unsigned days_in_month [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	int error_count = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;

	rtc_datetime_check_bcd_pack_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.epoch_we(epoch_we),
		.epoch_wdata(epoch_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** rtc_datetime_check_bcd_pack_core: FAILED **");
			$finish;
		end
	end

	function automatic logic [7:0] to_bcd2(int unsigned v);
		return {4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic rtcbcd_pkg::result_t predict_packed_date(rtcbcd_pkg::item_t it);
		rtcbcd_pkg::result_t r;
		bit leap;
		int unsigned limit;
		int unsigned span;
		r = '0;
		leap = ((it.year % 4) == 0 && (it.year % 100) != 0) || (it.year % 400) == 0;
		span = int'(it.year) - int'(epoch_shadow);
		if (it.month < 1 || it.month > 12 || it.day_of_month == 0) begin
			r.status = rtcbcd_pkg::ST_BAD_MON;
		end else begin
			limit = days_in_month[it.month] + ((it.month == 2 && leap) ? 1 : 0);
			if (it.day_of_month > limit) begin
				r.status = rtcbcd_pkg::ST_BAD_DAY;
			end else if (it.hour >= 24 || it.minute >= 60 || it.second >= 60) begin
				r.status = rtcbcd_pkg::ST_BAD_TIME;
			end else if (it.year < epoch_shadow || span > 255) begin
				r.status = rtcbcd_pkg::ST_BAD_YEAR;
			end else begin
				r.status = rtcbcd_pkg::ST_OK;
				r.bcd_second = to_bcd2(32'(it.second));
				r.bcd_minute = to_bcd2(32'(it.minute));
				r.bcd_hour = to_bcd2(32'(it.hour));
				r.bcd_day = to_bcd2(32'(it.day_of_month));
				r.bcd_weekday = to_bcd2(32'(it.weekday));
				r.bcd_month = to_bcd2(32'(it.month));
				r.bcd_year = to_bcd2(span % 100);
			end
		end
		return r;
	endfunction

	task automatic compare_field(string name, logic [7:0] exp, logic [7:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		rtcbcd_pkg::result_t exp;
		if (arst_n && done) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %0h", $time, result);
				error_count++;
			end else begin
				exp = expected_dates.pop_front();
				compare_field("status", 8'(exp.status), 8'(result.status));
				compare_field("bcd_second", exp.bcd_second, result.bcd_second);
				compare_field("bcd_minute", exp.bcd_minute, result.bcd_minute);
				compare_field("bcd_hour", exp.bcd_hour, result.bcd_hour);
				compare_field("bcd_day", exp.bcd_day, result.bcd_day);
				compare_field("bcd_weekday", exp.bcd_weekday, result.bcd_weekday);
				compare_field("bcd_month", exp.bcd_month, result.bcd_month);
				compare_field("bcd_year", exp.bcd_year, result.bcd_year);
			end
		end
	end

	function automatic rtcbcd_pkg::item_t make_date(int y, int mo, int d, int h, int mi, int s,
		int wd);
		rtcbcd_pkg::item_t it;
		it.year = 12'(y);
		it.month = 4'(mo);
		it.day_of_month = 5'(d);
		it.hour = 5'(h);
		it.minute = 6'(mi);
		it.second = 6'(s);
		it.weekday = 3'(wd);
		return it;
	endfunction

	function automatic rtcbcd_pkg::item_t random_date();
		rtcbcd_pkg::item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			it.year = 12'(int'(epoch_shadow) + $urandom_range(0, 255));
		else if (pick < 80)
			it.year = 12'(int'(epoch_shadow) + $urandom_range(256, 300));
		else if (pick < 88)
			it.year = 12'(int'(epoch_shadow) - $urandom_range(1, 20));
		else
			it.year = 12'($urandom_range(0, 4095));
		it.month = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 80)
			it.day_of_month = 5'($urandom_range(1, 28));
		else if (pick < 90)
			it.day_of_month = 5'($urandom_range(29, 31));
		else
			it.day_of_month = 5'($urandom_range(0, 31));
		it.hour = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23)) : 5'($urandom_range(0, 31));
		it.minute = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(0, 63));
		it.second = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59)) : 6'($urandom_range(0, 63));
		it.weekday = 3'($urandom_range(0, 7));
		return it;
	endfunction

	task automatic send_beat(rtcbcd_pkg::item_t it);
		logic held_off;
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= it;
		do begin
			@(negedge clk);
			held_off = busy;
			if (!held_off)
				expected_dates.push_back(predict_packed_date(it));
			@(posedge clk);
		end while (held_off);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_epoch(logic [11:0] value);
		drain_results();
		epoch_we <= 1'b1;
		epoch_wdata <= value;
		@(posedge clk);
		epoch_we <= 1'b0;
		epoch_shadow = value;
	endtask

	task automatic test_range_limits();
		send_beat(make_date(2000, 1, 1, 0, 0, 0, 0));
		send_beat(make_date(2255, 12, 31, 23, 59, 59, 7));
		send_beat(make_date(2256, 6, 15, 12, 30, 30, 3));
		send_beat(make_date(1999, 6, 15, 12, 30, 30, 3));
		send_beat(make_date(4095, 6, 15, 12, 30, 30, 5));
		send_beat(make_date(0, 6, 15, 12, 30, 30, 2));
		send_beat(make_date(2024, 0, 10, 1, 1, 1, 1));
		send_beat(make_date(2024, 13, 10, 1, 1, 1, 1));
		send_beat(make_date(2024, 15, 10, 1, 1, 1, 1));
		send_beat(make_date(2024, 5, 0, 1, 1, 1, 1));
		send_beat(make_date(2024, 4, 31, 1, 1, 1, 1));
		send_beat(make_date(2000, 2, 29, 8, 8, 8, 6));
		send_beat(make_date(2100, 2, 29, 8, 8, 8, 6));
		send_beat(make_date(2001, 2, 29, 8, 8, 8, 6));
		send_beat(make_date(2004, 2, 29, 8, 8, 8, 6));
		send_beat(make_date(2000, 2, 30, 8, 8, 8, 6));
		send_beat(make_date(2024, 7, 4, 24, 0, 0, 4));
		send_beat(make_date(2024, 7, 4, 31, 63, 63, 4));
		send_beat(make_date(2024, 7, 4, 0, 60, 0, 4));
		send_beat(make_date(2024, 7, 4, 0, 0, 60, 4));
	endtask

	task automatic test_check_order();
		send_beat(make_date(1999, 0, 0, 31, 63, 63, 7));
		send_beat(make_date(1999, 4, 31, 31, 63, 63, 7));
		send_beat(make_date(1999, 4, 30, 24, 0, 0, 7));
	endtask

	task automatic test_epoch_extremes();
		write_epoch(12'd0);
		send_beat(make_date(0, 2, 29, 0, 0, 0, 0));
		send_beat(make_date(255, 12, 31, 23, 59, 59, 7));
		send_beat(make_date(256, 1, 1, 0, 0, 0, 1));
		write_epoch(12'd4095);
		send_beat(make_date(4095, 12, 31, 23, 59, 59, 7));
		send_beat(make_date(4094, 12, 31, 23, 59, 59, 7));
		write_epoch(12'd3840);
		send_beat(make_date(4095, 3, 15, 10, 20, 30, 2));
	endtask

	task automatic test_random_dates();
		logic [11:0] epochs [0:8];
		epochs = '{12'd1970, 12'd0, 12'd4095, 12'd3840, 12'd2000,
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))};
		foreach (epochs[p]) begin
			write_epoch(epochs[p]);
			gaps_on = (p != 4);
			repeat (PHASE_BEATS) send_beat(random_date());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_limits();
		test_check_order();
		test_epoch_extremes();
		test_random_dates();
		drain_results();
		if (error_count == 0)
			$display("** rtc_datetime_check_bcd_pack_core: PASSED **");
		else
			$display("** rtc_datetime_check_bcd_pack_core: FAILED **");
		$finish;
	end

endmodule

>>> rtc_datetime_check_bcd_pack_core.f
design/rtcbcd_pkg.sv
design/rtcbcd_check.sv
design/rtcbcd_pack.sv
design/rtc_datetime_check_bcd_pack_core.sv
verif/testbench.sv
